// ===== rtl/bbl_pkg.sv =====
// ----------------------------------------------------------------------------
// bbl_pkg : shared types and constants of the byte budget LRU table
// Item structs, command and cell operation codes, table sizes.
// ----------------------------------------------------------------------------
package bbl_pkg;

  localparam int ENTRIES  = 64;
  localparam int SLOT_W   = 6;
  localparam int CNT_W    = 7;
  localparam int SIZE_W   = 32;
  localparam int ACC_W    = 38;  // exact sum of all entry sizes
  localparam int SUM_W    = 39;  // accumulator plus one chunk
  localparam int MIB_SHIFT = 20;
  localparam int STAT_W   = 48;
  localparam int USED_W   = 37;

  typedef enum logic [2:0] {
    CMD_LOOKUP  = 3'd0,
    CMD_INSERT  = 3'd1,
    CMD_REMOVE  = 3'd2,
    CMD_RM_SIG  = 3'd3,
    CMD_CLEAR   = 3'd4,
    CMD_TRIM    = 3'd5,
    CMD_RST_ST  = 3'd6,
    CMD_NONE    = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INSTALL,
    OP_PROMOTE,
    OP_DROP,
    OP_CLEAR
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_FIN
  } seq_state_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] signal_id;
    logic [47:0] first_row;
    logic [24:0] num_rows;
    logic [31:0] chunk_bytes;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [5:0]  slot;
    logic [6:0]  evicted;
    logic [6:0]  removed;
    logic [36:0] memory_used;
    logic [6:0]  entry_count;
    logic [47:0] hit_count;
    logic [47:0] miss_count;
  } out_item_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    cell_op_e            op;
    logic [SLOT_W-1:0]   tgt;
    logic [SLOT_W-1:0]   tgt_age;
    logic [SLOT_W-1:0]   lru_age;
    logic                set_size;
    logic [15:0]         signal_id;
    logic [47:0]         first_row;
    logic [24:0]         num_rows;
    logic [SIZE_W-1:0]   size;
  } cell_cmd_t;

  // status of one cell
  typedef struct packed {
    logic              valid;
    logic              key_hit;
    logic              is_lru;
    logic              free_sel;
    logic              sig_sel;
    logic [SLOT_W-1:0] age;
    logic [SIZE_W-1:0] size;
  } cell_stat_t;

  // priority chain passed from cell to cell
  typedef struct packed {
    logic free_taken;
    logic sig_taken;
  } cell_chain_t;

endpackage

// ===== rtl/bbl_cell.sv =====
// ----------------------------------------------------------------------------
// bbl_cell : one table slot
// Holds key, size and age rank of one entry, compares against the broadcast
// key and passes first-free / first-signal-match claims to the next cell.
// ----------------------------------------------------------------------------
module bbl_cell import bbl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [SLOT_W-1:0] idx,
  input  cell_cmd_t         cmd,
  input  cell_chain_t       chain_in,
  output cell_chain_t       chain_out,
  output cell_stat_t        stat
);

  logic              valid;
  logic [15:0]       signal;
  logic [47:0]       start;
  logic [24:0]       rows;
  logic [SIZE_W-1:0] size;
  logic [SLOT_W-1:0] age;
  logic              me;
  logic              sig_hit;

  assign me      = (idx == cmd.tgt);
  assign sig_hit = valid && (signal == cmd.signal_id);

  // status and chain
  always_comb begin
    stat.valid    = valid;
    stat.key_hit  = valid && (signal == cmd.signal_id) && (start == cmd.first_row)
                    && (rows == cmd.num_rows);
    stat.is_lru   = valid && (age == cmd.lru_age);
    stat.free_sel = !valid && !chain_in.free_taken;
    stat.sig_sel  = sig_hit && !chain_in.sig_taken;
    stat.age      = age;
    stat.size     = size;
    chain_out.free_taken = chain_in.free_taken || !valid;
    chain_out.sig_taken  = chain_in.sig_taken || sig_hit;
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_INSTALL: if (me) valid <= 1'b1;
        OP_DROP:    if (me) valid <= 1'b0;
        OP_CLEAR:   valid <= 1'b0;
        OP_NOP, OP_PROMOTE: ;
        default: ;
      endcase
    end
  end

  // key, size and age rank
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_INSTALL: begin
        if (me) begin
          signal <= cmd.signal_id;
          start  <= cmd.first_row;
          rows   <= cmd.num_rows;
          size   <= cmd.size;
          age    <= '0;
        end else if (valid) begin
          age <= age + 1'b1;
        end
      end
      OP_PROMOTE: begin
        if (me) begin
          age <= '0;
          if (cmd.set_size) size <= cmd.size;
        end else if (valid && age < cmd.tgt_age) begin
          age <= age + 1'b1;
        end
      end
      OP_DROP: begin
        if (!me && valid && age > cmd.tgt_age) age <= age - 1'b1;
      end
      OP_NOP, OP_CLEAR: ;
      default: ;
    endcase
  end

endmodule

// ===== rtl/byte_budget_lru_table_core.sv =====
// ----------------------------------------------------------------------------
// byte_budget_lru_table_core : size-aware LRU tag table
// Row of table cells driven by a small sequencer.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_item carries one command item; the
// output channel out_valid/out_stall/out_item returns exactly one result
// item per command. An item is taken when valid is high and stall is low.
// cfg_valid/cfg_ready/cfg_data writes the byte budget in MiB; cfg_ready is
// always high, write only while idle.
// One item at a time: every pass scans all cells (SCAN) and applies one
// cell operation (ACT); each evicted or signal-removed entry takes one
// more pass before the final state (FIN), and the next item is taken
// only after the sequencer is back in idle.
// The sequencer takes the next item once the result sits in the output
// register; if that register is still held by out_stall, the finished
// result waits in the final state and the input stays stalled.
// Synchronous reset empties the table, zeroes byte and hit/miss counters
// and sets the budget to 256 MiB; no clearing pass is needed.
// ----------------------------------------------------------------------------
module byte_budget_lru_table_core import bbl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [15:0] cfg_data
);

  seq_state_e        state, state_next;
  in_item_t          item;
  logic [15:0]       limit_mb;
  logic [ACC_W-1:0]  bytes, bytes_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [STAT_W-1:0] hits, hits_next, misses, misses_next;
  logic              found, found_next;
  logic [SLOT_W-1:0] slot, slot_next;
  logic [CNT_W-1:0]  evicted, evicted_next, removed, removed_next;

  // scan results
  logic              hit_any, sig_any, free_any;
  logic [SLOT_W-1:0] hit_slot, hit_age, lru_slot, lru_age, sig_slot, sig_age, free_slot;
  logic [SIZE_W-1:0] hit_size, lru_size, sig_size;
  logic              c_hit_any, c_sig_any, c_free_any;
  logic [SLOT_W-1:0] c_hit_slot, c_hit_age, c_lru_slot, c_lru_age, c_sig_slot, c_sig_age;
  logic [SLOT_W-1:0] c_free_slot;
  logic [SIZE_W-1:0] c_hit_size, c_lru_size, c_sig_size;

  cell_cmd_t         ccmd;
  cell_stat_t        stat [ENTRIES];
  cell_chain_t       chain [ENTRIES+1];
  logic [ENTRIES-1:0] valid_vec;

  logic [SUM_W-1:0]  budget, need;
  logic [SIZE_W-1:0] drop_size;
  logic              do_drop;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign chain[0]  = '0;

  // cell row
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    bbl_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (SLOT_W'(g)),
      .cmd       (ccmd),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1]),
      .stat      (stat[g])
    );
    assign valid_vec[g] = stat[g].valid;
  end

  // one-hot encode of the cell flags
  always_comb begin
    c_hit_any = 1'b0; c_sig_any = 1'b0; c_free_any = 1'b0;
    c_hit_slot = '0; c_hit_age = '0; c_hit_size = '0;
    c_lru_slot = '0; c_lru_age = '0; c_lru_size = '0;
    c_sig_slot = '0; c_sig_age = '0; c_sig_size = '0;
    c_free_slot = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (stat[i].key_hit) begin
        c_hit_any  = 1'b1;
        c_hit_slot = c_hit_slot | SLOT_W'(i);
        c_hit_age  = c_hit_age | stat[i].age;
        c_hit_size = c_hit_size | stat[i].size;
      end
      if (stat[i].is_lru) begin
        c_lru_slot = c_lru_slot | SLOT_W'(i);
        c_lru_age  = c_lru_age | stat[i].age;
        c_lru_size = c_lru_size | stat[i].size;
      end
      if (stat[i].sig_sel) begin
        c_sig_any  = 1'b1;
        c_sig_slot = c_sig_slot | SLOT_W'(i);
        c_sig_age  = c_sig_age | stat[i].age;
        c_sig_size = c_sig_size | stat[i].size;
      end
      if (stat[i].free_sel) begin
        c_free_any  = 1'b1;
        c_free_slot = c_free_slot | SLOT_W'(i);
      end
    end
  end

  // scan register
  always_ff @(posedge clk) begin
    if (state == S_SCAN) begin
      hit_any <= c_hit_any;   hit_slot <= c_hit_slot; hit_age <= c_hit_age;
      hit_size <= c_hit_size;
      lru_slot <= c_lru_slot; lru_age <= c_lru_age;   lru_size <= c_lru_size;
      sig_any <= c_sig_any;   sig_slot <= c_sig_slot; sig_age <= c_sig_age;
      sig_size <= c_sig_size;
      free_any <= c_free_any; free_slot <= c_free_slot;
    end
  end

  assign budget = SUM_W'({limit_mb, {MIB_SHIFT{1'b0}}});
  assign need   = SUM_W'(bytes) + SUM_W'(item.chunk_bytes);

  // sequencer: next state, cell operation and result fields
  always_comb begin
    state_next   = state;
    bytes_next   = bytes;
    count_next   = count;
    hits_next    = hits;
    misses_next  = misses;
    found_next   = found;
    slot_next    = slot;
    evicted_next = evicted;
    removed_next = removed;
    do_drop      = 1'b0;
    drop_size    = lru_size;
    ccmd.op        = OP_NOP;
    ccmd.tgt       = lru_slot;
    ccmd.tgt_age   = lru_age;
    ccmd.lru_age   = SLOT_W'(count - 1'b1);
    ccmd.set_size  = 1'b0;
    ccmd.signal_id = item.signal_id;
    ccmd.first_row = item.first_row;
    ccmd.num_rows  = item.num_rows;
    ccmd.size      = item.chunk_bytes;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next   = S_SCAN;
          found_next   = 1'b0;
          slot_next    = '0;
          evicted_next = '0;
          removed_next = '0;
        end
      end
      S_SCAN: state_next = S_ACT;
      S_ACT: begin
        state_next = S_FIN;
        unique case (cmd_e'(item.command))
          CMD_LOOKUP: begin
            if (hit_any) begin
              hits_next    = (&hits) ? hits : hits + 1'b1;
              ccmd.op      = OP_PROMOTE;
              ccmd.tgt     = hit_slot;
              ccmd.tgt_age = hit_age;
              found_next   = 1'b1;
              slot_next    = hit_slot;
            end else begin
              misses_next = (&misses) ? misses : misses + 1'b1;
            end
          end
          CMD_INSERT: begin
            if (hit_any) begin
              bytes_next    = ACC_W'(SUM_W'(bytes) - SUM_W'(hit_size)
                                     + SUM_W'(item.chunk_bytes));
              ccmd.op       = OP_PROMOTE;
              ccmd.tgt      = hit_slot;
              ccmd.tgt_age  = hit_age;
              ccmd.set_size = 1'b1;
              found_next    = 1'b1;
              slot_next     = hit_slot;
            end else if ((count != '0 && need > budget) || count == CNT_W'(ENTRIES)) begin
              do_drop      = 1'b1;
              evicted_next = evicted + 1'b1;
              state_next   = S_SCAN;
            end else if (free_any) begin
              ccmd.op    = OP_INSTALL;
              ccmd.tgt   = free_slot;
              bytes_next = ACC_W'(need);
              count_next = count + 1'b1;
              slot_next  = free_slot;
            end
          end
          CMD_REMOVE: begin
            if (hit_any) begin
              do_drop      = 1'b1;
              ccmd.tgt     = hit_slot;
              ccmd.tgt_age = hit_age;
              drop_size    = hit_size;
              found_next   = 1'b1;
              removed_next = CNT_W'(1);
              slot_next    = hit_slot;
            end
          end
          CMD_RM_SIG: begin
            if (sig_any) begin
              do_drop      = 1'b1;
              ccmd.tgt     = sig_slot;
              ccmd.tgt_age = sig_age;
              drop_size    = sig_size;
              removed_next = removed + 1'b1;
              state_next   = S_SCAN;
            end
          end
          CMD_CLEAR: begin
            ccmd.op      = OP_CLEAR;
            removed_next = count;
            count_next   = '0;
            bytes_next   = '0;
          end
          CMD_TRIM: begin
            if (count != '0 && SUM_W'(bytes) > budget) begin
              do_drop      = 1'b1;
              evicted_next = evicted + 1'b1;
              state_next   = S_SCAN;
            end
          end
          CMD_RST_ST: begin
            hits_next   = '0;
            misses_next = '0;
          end
          CMD_NONE: ;
        endcase
        // shared drop of one entry
        if (do_drop) begin
          ccmd.op    = OP_DROP;
          bytes_next = (ACC_W'(drop_size) > bytes) ? '0 : bytes - ACC_W'(drop_size);
          count_next = count - 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      limit_mb  <= 16'd256;
      bytes     <= '0;
      count     <= '0;
      hits      <= '0;
      misses    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      bytes  <= bytes_next;
      count  <= count_next;
      hits   <= hits_next;
      misses <= misses_next;
      if (cfg_valid && cfg_ready) limit_mb <= cfg_data;
      if (state == S_FIN && state_next == S_IDLE) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) item <= in_item;
    found   <= found_next;
    slot    <= slot_next;
    evicted <= evicted_next;
    removed <= removed_next;
    if (state == S_FIN && state_next == S_IDLE) begin
      out_item.found       <= found;
      out_item.slot        <= slot;
      out_item.evicted     <= evicted;
      out_item.removed     <= removed;
      out_item.memory_used <= (bytes > ACC_W'({USED_W{1'b1}})) ? {USED_W{1'b1}}
                              : bytes[USED_W-1:0];
      out_item.entry_count <= count;
      out_item.hit_count   <= hits;
      out_item.miss_count  <= misses;
    end
  end

  // checks
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> $countones(valid_vec) == 32'(count))
    else $error("entry count differs from valid cells");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("entry count above table size");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_SCAN)
    else $error("accepted item did not start a scan");

  a_found_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.found |-> out_item.evicted == '0)
    else $error("hit reported together with evictions");

endmodule

// ===== sim/tb_byte_budget_lru_table_core.sv =====
// ----------------------------------------------------------------------------
// tb_byte_budget_lru_table_core : self-checking bench for the LRU tag table
// A directed table of commands, then random command streams under several
// byte budgets. A local model of the table predicts the results, typed
// directed rows bring their own, and the result channel is checked in order.
// ----------------------------------------------------------------------------
module tb_byte_budget_lru_table_core import bbl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned USED_MAX = 64'h1F_FFFF_FFFF;
  localparam longint unsigned STAT_MAX = 64'hFFFF_FFFF_FFFF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 200;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [15:0] cfg_data = 16'd0;

  byte_budget_lru_table_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // model copy of the tag table
  bit              tag_valid [ENTRIES];
  logic [15:0]     tag_sig   [ENTRIES];
  logic [47:0]     tag_start [ENTRIES];
  logic [24:0]     tag_rows  [ENTRIES];
  logic [31:0]     tag_size  [ENTRIES];
  int              tag_age   [ENTRIES];
  longint unsigned acc_bytes;
  longint unsigned hits, misses;
  int              live;
  logic [15:0]     budget_mb;

  out_item_t result_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic int find_key(logic [15:0] s, logic [47:0] st, logic [24:0] r);
    for (int i = 0; i < ENTRIES; i++)
      if (tag_valid[i] && tag_sig[i] == s && tag_start[i] == st && tag_rows[i] == r)
        return i;
    return -1;
  endfunction

  function automatic int find_oldest();
    int best;
    best = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (tag_valid[i] && (best < 0 || tag_age[i] > tag_age[best])) best = i;
    return best;
  endfunction

  function automatic void drop_slot(int s);
    acc_bytes = (tag_size[s] > acc_bytes) ? 0 : acc_bytes - tag_size[s];
    for (int i = 0; i < ENTRIES; i++)
      if (tag_valid[i] && tag_age[i] > tag_age[s]) tag_age[i]--;
    tag_valid[s] = 0;
    if (live > 0) live--;
  endfunction

  function automatic void promote(int s);
    for (int i = 0; i < ENTRIES; i++)
      if (tag_valid[i] && tag_age[i] < tag_age[s]) tag_age[i]++;
    tag_age[s] = 0;
  endfunction

  function automatic longint unsigned budget_bytes();
    return longint'(budget_mb) << MIB_SHIFT;
  endfunction

  // apply one command to the model and return the result it should give
  function automatic out_item_t table_result(in_item_t it);
    out_item_t r;
    int s;
    longint unsigned sz;
    r = '0;
    sz = it.chunk_bytes;
    s = find_key(it.signal_id, it.first_row, it.num_rows);
    case (cmd_e'(it.command))
      CMD_LOOKUP: begin
        if (s >= 0) begin
          hits = (hits >= STAT_MAX) ? STAT_MAX : hits + 1;
          promote(s);
          r.found = 1'b1;
          r.slot = s[5:0];
        end else begin
          misses = (misses >= STAT_MAX) ? STAT_MAX : misses + 1;
        end
      end
      CMD_INSERT: begin
        if (s >= 0) begin
          acc_bytes = acc_bytes - tag_size[s] + sz;
          tag_size[s] = it.chunk_bytes;
          promote(s);
          r.found = 1'b1;
          r.slot = s[5:0];
        end else begin
          while (live > 0 && acc_bytes + sz > budget_bytes()) begin
            drop_slot(find_oldest());
            r.evicted++;
          end
          if (live >= ENTRIES) begin
            drop_slot(find_oldest());
            r.evicted++;
          end
          s = 0;
          while (tag_valid[s]) s++;
          for (int i = 0; i < ENTRIES; i++)
            if (tag_valid[i]) tag_age[i]++;
          tag_valid[s] = 1;
          tag_sig[s] = it.signal_id;
          tag_start[s] = it.first_row;
          tag_rows[s] = it.num_rows;
          tag_size[s] = it.chunk_bytes;
          tag_age[s] = 0;
          acc_bytes += sz;
          live++;
          r.slot = s[5:0];
        end
      end
      CMD_REMOVE: begin
        if (s >= 0) begin
          drop_slot(s);
          r.found = 1'b1;
          r.removed = 7'd1;
          r.slot = s[5:0];
        end
      end
      CMD_RM_SIG: begin
        for (int i = 0; i < ENTRIES; i++)
          if (tag_valid[i] && tag_sig[i] == it.signal_id) begin
            drop_slot(i);
            r.removed++;
          end
      end
      CMD_CLEAR: begin
        r.removed = live[6:0];
        for (int i = 0; i < ENTRIES; i++) tag_valid[i] = 0;
        live = 0;
        acc_bytes = 0;
      end
      CMD_TRIM: begin
        while (live > 0 && acc_bytes > budget_bytes()) begin
          drop_slot(find_oldest());
          r.evicted++;
        end
      end
      CMD_RST_ST: begin
        hits = 0;
        misses = 0;
      end
      default: ;
    endcase
    r.memory_used = (acc_bytes > USED_MAX) ? USED_MAX[36:0] : acc_bytes[36:0];
    r.entry_count = live[6:0];
    r.hit_count = hits[47:0];
    r.miss_count = misses[47:0];
    return r;
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item %p", out_item);
      end else begin
        out_item_t want;
        want = result_q.pop_front();
        if (out_item.found !== want.found || out_item.slot !== want.slot ||
            out_item.evicted !== want.evicted || out_item.removed !== want.removed ||
            out_item.memory_used !== want.memory_used ||
            out_item.entry_count !== want.entry_count ||
            out_item.hit_count !== want.hit_count ||
            out_item.miss_count !== want.miss_count) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", want, out_item);
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // watchdog on cycles without any accepted item
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // send one item; exp_given selects a typed expectation over the model's
  task automatic send_cmd(in_item_t it, bit exp_given, out_item_t exp_res);
    out_item_t r;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    r = table_result(it);
    result_q.insert(result_q.size(), exp_given ? exp_res : r);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // budget write once the table is quiet
  task automatic write_budget(logic [15:0] mb);
    in_valid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (4 + 2 * ENTRIES + 10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= mb;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    budget_mb = mb;
  endtask

  function automatic in_item_t mk(cmd_e c, logic [15:0] s, logic [47:0] st,
                                  logic [24:0] r, logic [31:0] b);
    in_item_t it;
    it.command = c;
    it.signal_id = s;
    it.first_row = st;
    it.num_rows = r;
    it.chunk_bytes = b;
    return it;
  endfunction

  function automatic out_item_t res(bit f, int sl, int ev, int rm, longint unsigned mem,
                                    int cnt, longint unsigned h, longint unsigned m);
    out_item_t o;
    o.found = f;
    o.slot = sl[5:0];
    o.evicted = ev[6:0];
    o.removed = rm[6:0];
    o.memory_used = mem[36:0];
    o.entry_count = cnt[6:0];
    o.hit_count = h[47:0];
    o.miss_count = m[47:0];
    return o;
  endfunction

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  function automatic in_item_t random_cmd();
    in_item_t it;
    int p;
    longint unsigned cap;
    p = $urandom_range(0, 99);
    if (p < 40)      it.command = CMD_INSERT;
    else if (p < 70) it.command = CMD_LOOKUP;
    else if (p < 80) it.command = CMD_REMOVE;
    else if (p < 85) it.command = CMD_RM_SIG;
    else if (p < 87) it.command = CMD_CLEAR;
    else if (p < 92) it.command = CMD_TRIM;
    else if (p < 95) it.command = CMD_RST_ST;
    else             it.command = CMD_NONE;
    it.signal_id = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    case ($urandom_range(0, 5))
      0: it.first_row = '0;
      1: it.first_row = '1;
      2, 3: it.first_row = 48'($urandom_range(1, 3));
      default: it.first_row = {16'($urandom), 32'($urandom)};
    endcase
    case ($urandom_range(0, 5))
      0: it.num_rows = '0;
      1: it.num_rows = 25'h100_0000;
      2, 3: it.num_rows = 25'($urandom_range(1, 2));
      default: it.num_rows = 25'($urandom_range(0, 1 << 24));
    endcase
    cap = budget_bytes() / 8;
    if (cap == 0) cap = 1000;
    if (cap > 64'hFFFF_FFFF) cap = 64'hFFFF_FFFF;
    if ($urandom_range(0, 9) == 0) it.chunk_bytes = $urandom;
    else it.chunk_bytes = 32'($urandom_range(0, 32'(cap)));
    return it;
  endfunction

  stim_row_t dir_rows[$];
  logic [15:0] budgets[6] = '{16'd256, 16'd0, 16'hFFFF, 16'd1, 16'd4, 16'd16};
  in_item_t fill_key;

  // append one row to the directed table
  function automatic void add_row(in_item_t it, bit typed, out_item_t want);
    stim_row_t row;
    row.it = it;
    row.typed = typed;
    row.want = want;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  initial begin
    for (int i = 0; i < ENTRIES; i++) tag_valid[i] = 0;
    acc_bytes = 0; hits = 0; misses = 0; live = 0; budget_mb = 16'd256;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: typed rows from reset state, rest predicted
    add_row(mk(CMD_LOOKUP, 0, 0, 0, 0), 1, res(0, 0, 0, 0, 0, 0, 0, 1));
    add_row(mk(CMD_INSERT, 0, 0, 0, 100), 1, res(0, 0, 0, 0, 100, 1, 0, 1));
    add_row(mk(CMD_LOOKUP, 0, 0, 0, 0), 1, res(1, 0, 0, 0, 100, 1, 1, 1));
    // update in place with the largest size
    add_row(mk(CMD_INSERT, 0, 0, 0, '1), 1, res(1, 0, 0, 0, 64'hFFFF_FFFF, 1, 1, 1));
    // new key at the field maxima evicts the oversized chunk
    add_row(mk(CMD_INSERT, '1, '1, 25'h100_0000, 0), 1, res(0, 0, 1, 0, 0, 1, 1, 1));
    add_row(mk(CMD_REMOVE, '1, '1, 25'h100_0000, 0), 1, res(1, 0, 0, 1, 0, 0, 1, 1));
    add_row(mk(CMD_REMOVE, '1, '1, 25'h100_0000, 0), 1, res(0, 0, 0, 0, 0, 0, 1, 1));
    // unused command reports status only
    add_row(mk(CMD_NONE, 0, 0, 0, 0), 1, res(0, 0, 0, 0, 0, 0, 1, 1));
    for (int k = 0; k < 4; k++)
      add_row(mk(CMD_INSERT, 5, 48'(k), 1, 1000), 0, '0);
    add_row(mk(CMD_INSERT, 6, 7, 7, 2000), 0, '0);
    add_row(mk(CMD_LOOKUP, 5, 2, 1, 0), 0, '0);
    // remove by signal ignores start and rows
    add_row(mk(CMD_RM_SIG, 5, '1, '1, 0), 0, '0);
    add_row(mk(CMD_LOOKUP, 5, 0, 1, 0), 0, '0);
    add_row(mk(CMD_INSERT, 7, 1, 1, 32'h0FFF_FFFF), 0, '0);
    add_row(mk(CMD_INSERT, 8, 1, 1, 32'h0FFF_FFFF), 0, '0);
    add_row(mk(CMD_TRIM, 0, 0, 0, 0), 0, '0);
    add_row(mk(CMD_RST_ST, 0, 0, 0, 0), 0, '0);
    add_row(mk(CMD_CLEAR, 0, 0, 0, 0), 0, '0);
    foreach (dir_rows[i]) send_cmd(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

    // accumulator beyond 37 bits: fill at the top budget then grow in place
    write_budget(16'hFFFF);
    for (int k = 0; k < ENTRIES; k++)
      send_cmd(mk(CMD_INSERT, 16'd9, 48'(k), 25'd3, 32'd16), 0, '0);
    for (int k = 0; k < ENTRIES; k++)
      send_cmd(mk(CMD_INSERT, 16'd9, 48'(k), 25'd3, '1), 0, '0);
    // lowered budget: write alone never evicts, trim does
    write_budget(16'd0);
    send_cmd(mk(CMD_LOOKUP, 16'd9, 48'd0, 25'd3, 0), 0, '0);
    send_cmd(mk(CMD_TRIM, 0, 0, 0, 0), 0, '0);

    // random streams under three idling regimes
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 58 : 0;
      recv_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 7 : 0;
      for (int seg = 0; seg < 5; seg++) begin
        write_budget((seg == 4) ? 16'($urandom) : budgets[(ph + seg) % 6]);
        for (int n = 0; n < 90; n++) send_cmd(random_cmd(), 0, '0);
      end
    end

    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
